>>> sv/lbc_pkg.sv
// Package for the LRU bank cache: widths, register indexes, controller states
// and the command/status structs shared by the controller and the datapath.
// No dependencies.
package lbc_pkg;

    localparam int MAX_SLOTS_DEF = 8;
    localparam int ACT_W         = 4;
    localparam int SIZE_W        = 17;
    localparam int CFG_DATA_W    = 17;
    localparam int BANK_W        = 8;
    localparam int OFFSET_W      = 24;
    localparam int STAMP_W       = 32;
    localparam int SLOT_OUT_W    = 3;
    localparam int CNT_W         = 6;

    localparam logic [BANK_W-1:0]  EMPTY_TAG     = 8'hFF;
    localparam logic [ACT_W-1:0]   ACTIVE_RESET  = 4'd8;
    localparam logic [SIZE_W-1:0]  BANK_SIZE_RST = 17'd8192;

    typedef enum logic [0:0] {
        REG_ACTIVE_SLOTS = 1'b0,
        REG_BANK_SIZE    = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_REPLACE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic lookup;
        logic scan;
        logic replace;
        logic emit;
    } lbc_cmd_t;

    typedef struct packed {
        logic inval;
        logic hit;
        logic single;
        logic scan_done;
        logic out_free;
    } lbc_sts_t;

endpackage

>>> sv/lbc_ctrl.sv
// Controller of the LRU bank cache: sequences lookup, victim scan, replace
// and result hand-off. Depends on lbc_pkg.
module lbc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lbc_pkg::lbc_sts_t sts,
    output lbc_pkg::lbc_cmd_t cmd
);
    import lbc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                if (sts.inval || sts.hit) begin
                    state_next = ST_EMIT;
                end else if (sts.single) begin
                    state_next = ST_REPLACE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_REPLACE;
                end
            end
            ST_REPLACE: begin
                cmd.replace = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/lbc_datapath.sv
// Datapath of the LRU bank cache: configuration, tags, stamps, use tick,
// victim scan, load offset multiply and the output register. Depends on lbc_pkg.
module lbc_datapath #(
    parameter int MAX_SLOTS = lbc_pkg::MAX_SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  lbc_pkg::cfg_reg_t                 cfg_index,
    input  logic [lbc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_mode,
    input  logic [lbc_pkg::BANK_W-1:0]        s_bank_number,
    input  logic                              s_rom_kind,
    input  lbc_pkg::lbc_cmd_t                 cmd,
    output lbc_pkg::lbc_sts_t                 sts,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lbc_pkg::SLOT_OUT_W-1:0]    m_slot,
    output logic                              m_hit,
    output logic                              m_load_request,
    output logic                              m_load_rom_kind,
    output logic [lbc_pkg::OFFSET_W-1:0]      m_load_offset
);
    import lbc_pkg::*;

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PROD_W = BANK_W + SIZE_W;

    logic [ACT_W-1:0]    active_slots_reg;
    logic [SIZE_W-1:0]   bank_size_reg;
    logic [BANK_W-1:0]   tag_reg [MAX_SLOTS];
    logic [STAMP_W-1:0]  stamp_reg [MAX_SLOTS];
    logic [STAMP_W-1:0]  tick_reg;
    logic [STAMP_W-1:0]  tick_next;

    logic                mode_reg;
    logic [BANK_W-1:0]   bank_reg;
    logic                kind_reg;

    logic [SLOT_W-1:0]   scan_idx_reg;
    logic [STAMP_W-1:0]  min_reg;
    logic [SLOT_W-1:0]   victim_reg;

    logic [SLOT_W-1:0]   res_slot_reg;
    logic                res_hit_reg;
    logic                res_load_reg;
    logic                res_kind_reg;
    logic [OFFSET_W-1:0] res_offset_reg;

    logic                m_valid_reg;
    logic [SLOT_OUT_W-1:0] m_slot_reg;
    logic                m_hit_reg;
    logic                m_load_reg;
    logic                m_kind_reg;
    logic [OFFSET_W-1:0] m_offset_reg;

    logic [CNT_W-1:0]    act_ext;
    logic [CNT_W-1:0]    n_use;
    logic [CNT_W-1:0]    last_ext;
    logic [SLOT_W-1:0]   last;
    logic [MAX_SLOTS-1:0] hit_vec;
    logic [SLOT_W-1:0]   hit_idx;
    logic [PROD_W-1:0]   prod;
    logic [CNT_W-1:0]    res_slot_ext;

    always_comb begin
        act_ext = CNT_W'(active_slots_reg);
        if (act_ext == '0) begin
            n_use = CNT_W'(1);
        end else if (act_ext > CNT_W'(MAX_SLOTS)) begin
            n_use = CNT_W'(MAX_SLOTS);
        end else begin
            n_use = act_ext;
        end
        last_ext = n_use - CNT_W'(1);
        last     = last_ext[SLOT_W-1:0];
    end

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            hit_vec[i] = (tag_reg[i] == bank_reg) && (CNT_W'(i) <= last_ext);
        end
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = SLOT_W'(i);
            end
        end
    end

    assign tick_next    = tick_reg + STAMP_W'(1);
    assign prod         = PROD_W'(bank_reg) * PROD_W'(bank_size_reg);
    assign res_slot_ext = CNT_W'(res_slot_reg);

    assign sts.inval     = mode_reg;
    assign sts.hit       = |hit_vec;
    assign sts.single    = (last_ext == '0);
    assign sts.scan_done = (scan_idx_reg == last);
    assign sts.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_slots_reg <= ACTIVE_RESET;
            bank_size_reg    <= BANK_SIZE_RST;
            tick_reg         <= '0;
            m_valid_reg      <= 1'b0;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                tag_reg[i]   <= EMPTY_TAG;
                stamp_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_ACTIVE_SLOTS: active_slots_reg <= cfg_wdata[ACT_W-1:0];
                    REG_BANK_SIZE:    bank_size_reg    <= cfg_wdata[SIZE_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.lookup) begin
                if (mode_reg) begin
                    tick_reg <= '0;
                    for (int i = 0; i < MAX_SLOTS; i++) begin
                        tag_reg[i]   <= EMPTY_TAG;
                        stamp_reg[i] <= '0;
                    end
                end else begin
                    tick_reg <= tick_next;
                    if (|hit_vec) begin
                        stamp_reg[hit_idx] <= tick_next;
                    end
                end
            end
            if (cmd.replace) begin
                tag_reg[victim_reg]   <= bank_reg;
                stamp_reg[victim_reg] <= tick_reg;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg <= s_mode;
            bank_reg <= s_bank_number;
            kind_reg <= s_rom_kind;
        end
        if (cmd.lookup) begin
            min_reg      <= stamp_reg[0];
            victim_reg   <= '0;
            scan_idx_reg <= SLOT_W'(1);
            res_slot_reg <= (mode_reg || !(|hit_vec)) ? '0 : hit_idx;
            res_hit_reg  <= !mode_reg && (|hit_vec);
            res_load_reg   <= 1'b0;
            res_kind_reg   <= 1'b0;
            res_offset_reg <= '0;
        end
        if (cmd.scan) begin
            if (stamp_reg[scan_idx_reg] < min_reg) begin
                min_reg    <= stamp_reg[scan_idx_reg];
                victim_reg <= scan_idx_reg;
            end
            scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
        end
        if (cmd.replace) begin
            res_slot_reg   <= victim_reg;
            res_hit_reg    <= 1'b0;
            res_load_reg   <= 1'b1;
            res_kind_reg   <= kind_reg;
            res_offset_reg <= prod[OFFSET_W-1:0];
        end
        if (cmd.emit) begin
            m_slot_reg   <= res_slot_ext[SLOT_OUT_W-1:0];
            m_hit_reg    <= res_hit_reg;
            m_load_reg   <= res_load_reg;
            m_kind_reg   <= res_kind_reg;
            m_offset_reg <= res_offset_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_slot          = m_slot_reg;
    assign m_hit           = m_hit_reg;
    assign m_load_request  = m_load_reg;
    assign m_load_rom_kind = m_kind_reg;
    assign m_load_offset   = m_offset_reg;

    a_inval_clears_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.lookup && mode_reg |=> tick_reg == '0)
        else $error("use tick not cleared by invalidate");

    a_hit_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_hit_reg |-> !m_load_reg)
        else $error("hit result carries a load request");

    a_victim_active: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.replace |-> CNT_W'(victim_reg) <= last_ext)
        else $error("victim slot outside the active slots");

    a_emit_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !m_valid_reg || m_ready)
        else $error("result register overwritten while stalled");

endmodule

>>> sv/lru_bank_cache.sv
// Top level of the LRU bank cache: joins the controller and the datapath.
// Depends on lbc_pkg, lbc_ctrl and lbc_datapath.
//
// Usage: a transaction on the s_ channel carries one item: s_mode 0 looks up
// bank s_bank_number, s_mode 1 invalidates the whole cache. Each item yields
// exactly one transaction on the m_ channel with the slot, a hit flag and, on
// a miss, a load request with the ROM kind and byte offset.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata while
// the block is idle; each write takes effect at the next edge.
// Flow: the input is taken in the idle state. A hit or an invalidate goes
// from the lookup straight to the result hand-off; a miss scans the stamps
// one slot per cycle (no scan with a single active slot) and then replaces
// the victim before the hand-off. The next item is taken in the cycle after
// the result is loaded into the output register, never while an item is in
// work. A stalled receiver holds the result in the output register; the
// block still accepts and works on the next item and waits only when that
// item's result is ready.
// Reset: all slots empty (tag 255), stamps and tick zero, 8 active slots,
// bank size 8192, no result pending.
module lru_bank_cache #(
    parameter int MAX_SLOTS = lbc_pkg::MAX_SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  lbc_pkg::cfg_reg_t                 cfg_index,
    input  logic [lbc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [lbc_pkg::BANK_W-1:0]        s_bank_number,
    input  logic                              s_rom_kind,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lbc_pkg::SLOT_OUT_W-1:0]    m_slot,
    output logic                              m_hit,
    output logic                              m_load_request,
    output logic                              m_load_rom_kind,
    output logic [lbc_pkg::OFFSET_W-1:0]      m_load_offset
);
    import lbc_pkg::*;

    lbc_cmd_t cmd;
    lbc_sts_t sts;

    lbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lbc_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_mode          (s_mode),
        .s_bank_number   (s_bank_number),
        .s_rom_kind      (s_rom_kind),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_slot          (m_slot),
        .m_hit           (m_hit),
        .m_load_request  (m_load_request),
        .m_load_rom_kind (m_load_rom_kind),
        .m_load_offset   (m_load_offset)
    );

endmodule

>>> sim/lru_bank_cache_tb.sv
// Self-checking testbench for lru_bank_cache: directed, register-extreme,
// back-pressure and random tests, each result compared with a behavioral cache.
// Depends on lbc_pkg and the lru_bank_cache RTL.
module lru_bank_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbc_pkg::*;

    localparam int SLOTS        = MAX_SLOTS_DEF;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 1000;

    localparam logic MODE_ACCESS     = 1'b0;
    localparam logic MODE_INVALIDATE = 1'b1;
    localparam logic ROM_PROGRAM     = 1'b0;
    localparam logic ROM_CHARACTER   = 1'b1;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic                  hit;
        logic                  load_request;
        logic                  load_rom_kind;
        logic [OFFSET_W-1:0]   load_offset;
    } bank_result_t;

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  cfg_wr_en       = 1'b0;
    cfg_reg_t              cfg_index       = REG_ACTIVE_SLOTS;
    logic [CFG_DATA_W-1:0] cfg_wdata       = '0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic                  s_mode          = MODE_ACCESS;
    logic [BANK_W-1:0]     s_bank_number   = '0;
    logic                  s_rom_kind      = ROM_PROGRAM;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [SLOT_OUT_W-1:0] m_slot;
    logic                  m_hit;
    logic                  m_load_request;
    logic                  m_load_rom_kind;
    logic [OFFSET_W-1:0]   m_load_offset;

    logic [BANK_W-1:0]     slot_tags   [SLOTS];
    logic [STAMP_W-1:0]    slot_stamps [SLOTS];
    logic [STAMP_W-1:0]    access_tick;
    logic [ACT_W-1:0]      active_setting;
    logic [SIZE_W-1:0]     bank_bytes;
    bank_result_t          pending_results[$];
    bank_result_t          oldest_result;

    bit                    idle_on     = 1'b0;
    bit                    hold_req    = 1'b0;
    logic [BANK_W-1:0]     work_base   = '0;
    int                    work_span   = 10;
    int unsigned           cycle_count = 0;
    int                    mismatches  = 0;
    int                    items_sent  = 0;
    int                    hits        = 0;
    int                    misses      = 0;
    int                    invalidates = 0;
    int                    reg_writes  = 0;
    int                    hold_count  = 0;

    lru_bank_cache uut (.*);

    always #1 aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_count, pending_results.size());
        $display("lru_bank_cache_tb: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < 100) $display("[%0t] MISMATCH %s", $time, what);
        mismatches++;
    endtask

    function automatic int slots_used();
        if (active_setting == '0) return 1;
        if (active_setting > SLOTS) return SLOTS;
        return int'(active_setting);
    endfunction

    function automatic void clear_cache();
        access_tick = '0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_tags[i]   = EMPTY_TAG;
            slot_stamps[i] = '0;
        end
    endfunction

    function automatic bank_result_t cache_access(input logic mode,
                                                  input logic [BANK_W-1:0] bank,
                                                  input logic kind);
        bank_result_t res;
        int           n;
        int           victim;
        bit           found;
        logic [24:0]  product;
        res = '0;
        if (mode == MODE_INVALIDATE) begin
            clear_cache();
            invalidates++;
            return res;
        end
        n = slots_used();
        access_tick = access_tick + 1;
        found = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (!found && slot_tags[i] == bank) begin
                found          = 1'b1;
                slot_stamps[i] = access_tick;
                res.slot       = SLOT_OUT_W'(i);
                res.hit        = 1'b1;
            end
        end
        if (found) begin
            hits++;
            return res;
        end
        victim = 0;
        for (int i = 1; i < n; i++) begin
            if (slot_stamps[i] < slot_stamps[victim]) victim = i;
        end
        slot_tags[victim]   = bank;
        slot_stamps[victim] = access_tick;
        product             = 25'(bank) * 25'(bank_bytes);
        res.slot            = SLOT_OUT_W'(victim);
        res.load_request    = 1'b1;
        res.load_rom_kind   = kind;
        res.load_offset     = product[OFFSET_W-1:0];
        misses++;
        return res;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    task automatic send_item(input logic mode, input logic [BANK_W-1:0] bank,
                             input logic kind);
        int gap;
        gap = idle_on ? idle_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_bank_number <= bank;
        s_rom_kind    <= kind;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        pending_results.push_back(cache_access(mode, bank, kind));
        items_sent++;
    endtask

    task automatic send_mixed_item(input int inval_pct);
        int   r;
        logic kind;
        r    = $urandom_range(0, 99);
        kind = 1'($urandom);
        if (r < inval_pct)
            send_item(MODE_INVALIDATE, BANK_W'($urandom), kind);
        else if (r < inval_pct + 10)
            send_item(MODE_ACCESS, BANK_W'($urandom), kind);
        else
            send_item(MODE_ACCESS, BANK_W'(work_base + $urandom_range(0, work_span)), kind);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == REG_ACTIVE_SLOTS) active_setting = value[ACT_W-1:0];
        else bank_bytes = value[SIZE_W-1:0];
        reg_writes++;
    endtask

    // The receiver alternates ready and stall stretches while idle gaps are on
    // and else stays ready; a hold request blocks it for a long, fixed stretch so the block backs up.
    initial begin
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                hold_count++;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (idle_gap() + 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transaction with no item outstanding");
            end else begin
                oldest_result = pending_results.pop_front();
                if (m_slot !== oldest_result.slot)
                    report_mismatch($sformatf("slot: got %0d, expected %0d",
                                              m_slot, oldest_result.slot));
                if (m_hit !== oldest_result.hit)
                    report_mismatch($sformatf("hit: got %0b, expected %0b",
                                              m_hit, oldest_result.hit));
                if (m_load_request !== oldest_result.load_request)
                    report_mismatch($sformatf("load_request: got %0b, expected %0b",
                                              m_load_request, oldest_result.load_request));
                if (m_load_rom_kind !== oldest_result.load_rom_kind)
                    report_mismatch($sformatf("load_rom_kind: got %0b, expected %0b",
                                              m_load_rom_kind, oldest_result.load_rom_kind));
                if (m_load_offset !== oldest_result.load_offset)
                    report_mismatch($sformatf("load_offset: got 0x%06h, expected 0x%06h",
                                              m_load_offset, oldest_result.load_offset));
            end
        end
    end

    task automatic test_directed();
        send_item(MODE_ACCESS, 8'd0, ROM_PROGRAM);
        send_item(MODE_ACCESS, 8'd255, ROM_CHARACTER);
        send_item(MODE_ACCESS, 8'd254, ROM_CHARACTER);
        send_item(MODE_ACCESS, 8'd0, ROM_PROGRAM);
        for (int b = 1; b <= 6; b++) send_item(MODE_ACCESS, BANK_W'(b), 1'(b));
        send_item(MODE_ACCESS, 8'd1, ROM_PROGRAM);
        send_item(MODE_ACCESS, 8'd100, ROM_CHARACTER);
        send_item(MODE_INVALIDATE, 8'd255, ROM_CHARACTER);
        send_item(MODE_ACCESS, 8'd255, ROM_PROGRAM);
        send_item(MODE_ACCESS, 8'd170, ROM_CHARACTER);
        send_item(MODE_ACCESS, 8'd85, ROM_PROGRAM);
        send_item(MODE_INVALIDATE, 8'd0, ROM_PROGRAM);
        wait_idle();
    endtask

    // Slot counts of zero and above the slot total saturate; bank sizes of
    // zero and above 16 bits exercise the wrapped offset. The cache is not
    // invalidated between settings, so shrunk slots come back with old tags.
    task automatic test_register_extremes();
        int unsigned act_vals  [6] = '{1, 0, 15, 9, 3, 8};
        int unsigned size_vals [6] = '{1, 65536, 0, 131071, 65535, 8192};
        int unsigned base_vals [6] = '{0, 252, 250, 120, 7, 64};
        for (int k = 0; k < 6; k++) begin
            write_reg(REG_ACTIVE_SLOTS, CFG_DATA_W'(act_vals[k]));
            write_reg(REG_BANK_SIZE, CFG_DATA_W'(size_vals[k]));
            work_base = BANK_W'(base_vals[k]);
            work_span = slots_used() + 2;
            idle_on   = (k % 2 == 1);
            repeat (20) send_mixed_item(5);
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (16) send_mixed_item(0);
        wait_idle();
    endtask

    task automatic test_random();
        int random_sent;
        int phase;
        int r;
        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 3);
            if (r != 0) begin
                if ($urandom_range(0, 9) < 7)
                    write_reg(REG_ACTIVE_SLOTS, CFG_DATA_W'($urandom_range(1, SLOTS)));
                else
                    write_reg(REG_ACTIVE_SLOTS,
                              {13'($urandom), 4'($urandom_range(0, 15))});
            end
            if (r != 1) begin
                case ($urandom_range(0, 9))
                    0:       write_reg(REG_BANK_SIZE, 17'd1);
                    1:       write_reg(REG_BANK_SIZE, 17'd65536);
                    2:       write_reg(REG_BANK_SIZE, 17'd0);
                    3:       write_reg(REG_BANK_SIZE, 17'd131071);
                    4, 5, 6: write_reg(REG_BANK_SIZE, 17'($urandom_range(1, 65536)));
                    default: write_reg(REG_BANK_SIZE, 17'($urandom));
                endcase
            end
            work_base = ($urandom_range(0, 4) == 0) ? 8'd250 : BANK_W'($urandom);
            work_span = slots_used() + $urandom_range(0, 4);
            idle_on   = ($urandom_range(0, 3) != 0);
            if (phase == 2) hold_req = 1'b1;
            repeat ($urandom_range(20, 80)) begin
                send_mixed_item(3);
                random_sent++;
            end
            wait_idle();
            phase++;
        end
    endtask

    initial begin
        active_setting = ACTIVE_RESET;
        bank_bytes     = BANK_SIZE_RST;
        clear_cache();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_register_extremes();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("Run covered %0d items: %0d hits, %0d misses, %0d invalidates, %0d register writes.",
                 items_sent, hits, misses, invalidates, reg_writes);
        $display("Receiver held off %0d times for %0d cycles each; %0d mismatches found.",
                 hold_count, HOLD_CYCLES, mismatches);
        if (mismatches == 0) begin
            $display("lru_bank_cache_tb: PASS");
        end else begin
            $display("lru_bank_cache_tb: FAIL");
        end
        $finish;
    end

endmodule
